// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthands for clocked assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/dtp_pkg.sv =====
// ----------------------------------------------------------------------------
// dtp_pkg
// Types and constants shared by the delay timer pool and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtp_pkg;

    // Default pool size and counter width.
    localparam int DTP_NUM_SLOTS   = 10;
    localparam int DTP_COUNT_WIDTH = 32;

    // Fixed field widths.
    localparam int MASK_W       = 10;
    localparam int TICKS_W      = 32;
    localparam int SLOT_W       = 4;
    localparam int PERIOD_W     = 16;
    localparam int ACTION_W     = 2;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 32;

    localparam logic [PERIOD_W-1:0] FLAG_PERIOD_RESET = 16'd500;

    // Result bit positions inside m_tdata.
    localparam int OUT_GRANTED_LSB = 0;
    localparam int OUT_SLOT_LSB    = 1;
    localparam int OUT_FULL_LSB    = 5;
    localparam int OUT_DONE_LSB    = 6;
    localparam int OUT_BUSY_LSB    = 16;
    localparam int OUT_FLAG_LSB    = 26;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK    = 2'd0,
        ACT_ALLOC   = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_CLEAR   = 2'd3
    } action_t;

    // Command to one slot for the item being processed.
    typedef struct packed {
        logic tick;
        logic load;
        logic clear;
    } slot_cmd_t;

    // Slot status: current state and the state after this cycle's command.
    typedef struct packed {
        logic busy;
        logic done;
        logic busy_next;
        logic done_next;
    } slot_stat_t;

endpackage

// ===== sv/dtp_slot.sv =====
// ----------------------------------------------------------------------------
// dtp_slot
// One countdown slot: busy mark, done mark and remaining tick count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtp_slot
    import dtp_pkg::*;
#(
    parameter int COUNT_WIDTH = DTP_COUNT_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  slot_cmd_t              cmd,
    input  logic [COUNT_WIDTH-1:0] load_value,
    output slot_stat_t             stat
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [COUNT_WIDTH-1:0] remaining_reg, remaining_next;

    // Clear has priority, then load, then a countdown step.
    always_comb
    begin
        busy_next      = busy_reg;
        done_next      = done_reg;
        remaining_next = remaining_reg;
        if (cmd.clear)
        begin
            busy_next      = 1'b0;
            done_next      = 1'b0;
            remaining_next = '0;
        end
        else if (cmd.load)
        begin
            busy_next      = 1'b1;
            remaining_next = load_value;
        end
        else if (cmd.tick && busy_reg && !done_reg)
        begin
            // A zero count expires at once; otherwise expire when the step reaches zero.
            if (remaining_reg == '0)
            begin
                done_next = 1'b1;
            end
            else
            begin
                remaining_next = remaining_reg - COUNT_WIDTH'(1);
                if (remaining_reg == COUNT_WIDTH'(1))
                begin
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            remaining_reg <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            done_reg      <= done_next;
            remaining_reg <= remaining_next;
        end
    end

    assign stat.busy      = busy_reg;
    assign stat.done      = done_reg;
    assign stat.busy_next = busy_next;
    assign stat.done_next = done_next;

endmodule

// ===== sv/delay_timer_pool.sv =====
// ----------------------------------------------------------------------------
// delay_timer_pool
// Pool of countdown delay slots with allocate, release, tick and flag clear.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the s_ stream: s_tuser carries the action (tick, allocate,
// release, clear flag), s_tdata the duration, slot index and channel-0 expiry.
// Every accepted item gives exactly one result on the m_ stream with the grant
// outcome, the done and busy masks after the item, and the sticky period flag.
// The user must write the flag period register through cfg_we / cfg_wdata
// only while idle; the block does not enforce it. Each item passes one input
// register, then one pass of slot logic into the result register.
// Throughput is one item per cycle while the receiver takes results; all
// slots update in parallel and the lowest free slot comes from a priority
// encoder in the same pass.
// When the receiver stalls, the result register holds and the input register
// takes one more item; s_tready then drops until the result is taken.
// Reset clears all slots, the prescaler, the flag and both stream stages,
// and loads the flag period with 500.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module delay_timer_pool
    import dtp_pkg::*;
#(
    parameter int NUM_SLOTS   = DTP_NUM_SLOTS,
    parameter int COUNT_WIDTH = DTP_COUNT_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration: flag_period
    input  logic                  cfg_we,
    input  logic [PERIOD_W-1:0]   cfg_wdata,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // delay_ticks[31:0], slot[35:32], prescale_tick[36]
    input  logic [ACTION_W-1:0]   s_tuser,   // action[1:0]
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // granted[0], grant_slot[4:1], pool_full[5],
                                             // done_mask[15:6], busy_mask[25:16],
                                             // period_flag[26]
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Input register stage.
    logic                  in_valid_reg;
    action_t               action_reg;
    logic [TICKS_W-1:0]    ticks_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic                  ptick_reg;

    // Result register stage.
    logic                  out_valid_reg;
    logic [M_TDATA_W-1:0]  out_data_reg, out_data_next;

    // Control state.
    logic [PERIOD_W-1:0]   period_reg;
    logic [PERIOD_W-1:0]   pcount_reg, pcount_next;
    logic                  flag_reg, flag_next;

    logic                  s_xfer;
    logic                  advance;
    logic [NUM_SLOTS-1:0]  busy_now;
    logic [NUM_SLOTS-1:0]  busy_after;
    logic [NUM_SLOTS-1:0]  done_after;
    logic [MASK_W-1:0]     busy_mask;
    logic [MASK_W-1:0]     done_mask;
    logic [IDX_W-1:0]      free_idx;
    logic                  free_found;
    logic [COUNT_WIDTH-1:0] load_value;
    logic [63:0]           ticks_ext;
    logic [PERIOD_W:0]     pcount_inc;
    slot_cmd_t             cmd [NUM_SLOTS];
    slot_stat_t            stat [NUM_SLOTS];

    // Stream handshakes: the input stage moves on when the result stage is free.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !out_valid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_xfer)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input payload capture.
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            action_reg <= action_t'(s_tuser);
            ticks_reg  <= s_tdata[TICKS_W-1:0];
            slot_reg   <= s_tdata[TICKS_W+SLOT_W-1:TICKS_W];
            ptick_reg  <= s_tdata[TICKS_W+SLOT_W];
        end
    end

    // Loaded duration keeps only the low COUNT_WIDTH bits.
    assign ticks_ext  = 64'(ticks_reg);
    assign load_value = ticks_ext[COUNT_WIDTH-1:0];

    // Lowest free slot.
    always_comb
    begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!busy_now[i])
            begin
                free_idx   = IDX_W'(i);
                free_found = 1'b1;
            end
        end
    end

    // Slot row with per-slot commands.
    for (genvar g = 0; g < NUM_SLOTS; g++)
    begin : g_slot
        always_comb
        begin
            cmd[g].tick  = advance && (action_reg == ACT_TICK);
            cmd[g].load  = advance && (action_reg == ACT_ALLOC) && free_found
                           && (free_idx == IDX_W'(g));
            cmd[g].clear = advance && (action_reg == ACT_RELEASE)
                           && (32'(slot_reg) == g);
        end

        dtp_slot #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_slot (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd[g]),
            .load_value (load_value),
            .stat       (stat[g])
        );

        assign busy_now[g]   = stat[g].busy;
        assign busy_after[g] = stat[g].busy_next;
        assign done_after[g] = stat[g].done_next;
    end

    // Reported masks cover at most the first MASK_W slots.
    for (genvar m = 0; m < MASK_W; m++)
    begin : g_mask
        if (m < NUM_SLOTS)
        begin : g_live
            assign busy_mask[m] = busy_after[m];
            assign done_mask[m] = done_after[m];
        end
        else
        begin : g_none
            assign busy_mask[m] = 1'b0;
            assign done_mask[m] = 1'b0;
        end
    end

    // Prescaler and sticky period flag.
    assign pcount_inc = {1'b0, pcount_reg} + (PERIOD_W+1)'(1);

    always_comb
    begin
        pcount_next = pcount_reg;
        flag_next   = flag_reg;
        if (advance)
        begin
            case (action_reg)
                ACT_TICK:
                begin
                    if (ptick_reg)
                    begin
                        if (pcount_inc >= {1'b0, period_reg})
                        begin
                            pcount_next = '0;
                            flag_next   = 1'b1;
                        end
                        else
                        begin
                            pcount_next = pcount_inc[PERIOD_W-1:0];
                        end
                    end
                end
                ACT_CLEAR:
                begin
                    flag_next = 1'b0;
                end
                default:
                begin
                    flag_next = flag_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= FLAG_PERIOD_RESET;
            pcount_reg <= '0;
            flag_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                period_reg <= cfg_wdata;
            end
            pcount_reg <= pcount_next;
            flag_reg   <= flag_next;
        end
    end

    // Result assembly.
    always_comb
    begin
        out_data_next = '0;
        if (action_reg == ACT_ALLOC)
        begin
            out_data_next[OUT_GRANTED_LSB] = free_found;
            out_data_next[OUT_FULL_LSB]    = !free_found;
            if (free_found)
            begin
                out_data_next[OUT_SLOT_LSB+SLOT_W-1:OUT_SLOT_LSB] = SLOT_W'(free_idx);
            end
        end
        out_data_next[OUT_DONE_LSB+MASK_W-1:OUT_DONE_LSB] = done_mask;
        out_data_next[OUT_BUSY_LSB+MASK_W-1:OUT_BUSY_LSB] = busy_mask;
        out_data_next[OUT_FLAG_LSB]                       = flag_next;
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== sv/dtp_checker.sv =====
// ----------------------------------------------------------------------------
// dtp_port_checker
// Port-level assertions for the delay timer pool, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dtp_port_checker
    import dtp_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [MASK_W-1:0] done_m;
    logic [MASK_W-1:0] busy_m;
    logic [SLOT_W-1:0] slot_m;
    logic              granted;
    logic              full;
    logic              stall;

    assign done_m  = m_tdata[OUT_DONE_LSB+MASK_W-1:OUT_DONE_LSB];
    assign busy_m  = m_tdata[OUT_BUSY_LSB+MASK_W-1:OUT_BUSY_LSB];
    assign slot_m  = m_tdata[OUT_SLOT_LSB+SLOT_W-1:OUT_SLOT_LSB];
    assign granted = m_tdata[OUT_GRANTED_LSB];
    assign full    = m_tdata[OUT_FULL_LSB];
    assign stall   = m_tvalid && !m_tready;

    // A stalled result stays valid and unchanged.
    `ASSERT_NEXT(a_hold, clk, rst_n, stall, m_tvalid && $stable(m_tdata), "stalled result changed")

    // An allocate either succeeds or reports a full pool, never both.
    `ASSERT_SAME(a_grant_full, clk, rst_n, m_tvalid, !(granted && full), "granted and pool_full")

    // Only an allocated slot can be marked done.
    `ASSERT_SAME(a_done_busy, clk, rst_n, m_tvalid, (done_m & ~busy_m) == '0, "done slot not busy")

    // The slot number is zero unless a grant is reported.
    `ASSERT_SAME(a_slot_zero, clk, rst_n, m_tvalid && !granted, slot_m == '0, "slot without grant")

endmodule

bind delay_timer_pool dtp_port_checker u_dtp_port_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== dv/dtp_checker.sv =====
// ----------------------------------------------------------------------------
// dtp_checker
// Watches the delay timer pool's streams, predicts each result and compares.
// ----------------------------------------------------------------------------
// Every input transfer is run through a local model of the slot pool and the
// prescaler. The predicted result is queued. Every result transfer is then
// compared field by field with the oldest queued prediction. Writes to the
// flag period register are tracked so the model uses the same period.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtp_checker
    import dtp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [PERIOD_W-1:0]   cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // delay_ticks[31:0], slot[35:32], prescale_tick[36]
    input  logic [ACTION_W-1:0]   s_tuser,   // action[1:0]
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,   // granted[0], grant_slot[4:1], pool_full[5],
                                             // done_mask[15:6], busy_mask[25:16],
                                             // period_flag[26]
    output int                    fail_count,
    output int                    pending,
    output int                    item_count,
    output int                    result_count,
    output int                    grant_count,
    output int                    full_count,
    output int                    flag_sets
);

    typedef struct packed {
        logic                 granted;
        logic [SLOT_W-1:0]    grant_slot;
        logic                 pool_full;
        logic [MASK_W-1:0]    done_mask;
        logic [MASK_W-1:0]    busy_mask;
        logic                 period_flag;
    } pool_result_t;

    // Model of the slot pool and prescaler.
    logic [DTP_COUNT_WIDTH-1:0] slot_count [DTP_NUM_SLOTS];
    logic                       slot_busy  [DTP_NUM_SLOTS];
    logic                       slot_done  [DTP_NUM_SLOTS];
    logic [PERIOD_W-1:0]        prescaler;
    logic [PERIOD_W-1:0]        period;
    logic                       flag_held;

    // Predictions waiting for their result transfer.
    pool_result_t pool_results_q [$];
    pool_result_t got;
    pool_result_t want;
    pool_result_t next_result;

    int n_fail;
    int n_items;
    int n_results;
    int n_grants;
    int n_full;
    int n_flag_sets;

    // Updates the pool model for one item and returns the result it gives.
    task automatic apply_pool_item(input action_t act, input logic [TICKS_W-1:0] dly,
                                   input logic [SLOT_W-1:0] sl, input logic ch0,
                                   output pool_result_t r);
        logic [PERIOD_W:0] next_count;
        r = '0;
        case (act)
            ACT_TICK:
            begin
                // A channel-0 expiry advances the prescaler; reaching the period sets the flag.
                if (ch0)
                begin
                    next_count = {1'b0, prescaler} + (PERIOD_W+1)'(1);
                    if (next_count >= {1'b0, period})
                    begin
                        prescaler = '0;
                        flag_held = 1'b1;
                        n_flag_sets++;
                    end
                    else
                    begin
                        prescaler = next_count[PERIOD_W-1:0];
                    end
                end
                // Busy slots that have not expired count down; zero means done.
                for (int i = 0; i < DTP_NUM_SLOTS; i++)
                begin
                    if (slot_busy[i] && !slot_done[i])
                    begin
                        if (slot_count[i] == '0)
                        begin
                            slot_done[i] = 1'b1;
                        end
                        else
                        begin
                            slot_count[i] = slot_count[i] - DTP_COUNT_WIDTH'(1);
                            if (slot_count[i] == '0)
                                slot_done[i] = 1'b1;
                        end
                    end
                end
            end
            ACT_ALLOC:
            begin
                // The lowest free slot is claimed; with none free the pool reports full.
                r.pool_full = 1'b1;
                for (int i = 0; i < DTP_NUM_SLOTS; i++)
                begin
                    if (!slot_busy[i] && !r.granted)
                    begin
                        slot_busy[i]  = 1'b1;
                        slot_count[i] = dly[DTP_COUNT_WIDTH-1:0];
                        r.granted     = 1'b1;
                        r.grant_slot  = i[SLOT_W-1:0];
                        r.pool_full   = 1'b0;
                    end
                end
                if (r.granted)
                    n_grants++;
                else
                    n_full++;
            end
            ACT_RELEASE:
            begin
                // Slots past the end of the pool are ignored.
                if (sl < DTP_NUM_SLOTS)
                begin
                    slot_count[sl] = '0;
                    slot_busy[sl]  = 1'b0;
                    slot_done[sl]  = 1'b0;
                end
            end
            ACT_CLEAR:
            begin
                flag_held = 1'b0;
            end
        endcase
        for (int i = 0; i < DTP_NUM_SLOTS && i < MASK_W; i++)
        begin
            r.done_mask[i] = slot_done[i];
            r.busy_mask[i] = slot_busy[i];
        end
        r.period_flag = flag_held;
    endtask

    // Reports one field that differs from its prediction.
    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
            n_fail++;
        end
    endtask

    // Track configuration, compare results, then predict newly accepted items.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DTP_NUM_SLOTS; i++)
            begin
                slot_count[i] = '0;
                slot_busy[i]  = 1'b0;
                slot_done[i]  = 1'b0;
            end
            prescaler = '0;
            flag_held = 1'b0;
            period    = FLAG_PERIOD_RESET;
            pool_results_q.delete();
        end
        else
        begin
            if (cfg_we)
                period = cfg_wdata;

            if (m_tvalid && m_tready)
            begin
                n_results++;
                got.granted     = m_tdata[OUT_GRANTED_LSB];
                got.grant_slot  = m_tdata[OUT_SLOT_LSB +: SLOT_W];
                got.pool_full   = m_tdata[OUT_FULL_LSB];
                got.done_mask   = m_tdata[OUT_DONE_LSB +: MASK_W];
                got.busy_mask   = m_tdata[OUT_BUSY_LSB +: MASK_W];
                got.period_flag = m_tdata[OUT_FLAG_LSB];
                if (pool_results_q.size() == 0)
                begin
                    $display("%0t: result with no prediction waiting, expected none, actual %0h",
                             $time, m_tdata);
                    n_fail++;
                end
                else
                begin
                    want = pool_results_q.pop_front();
                    check_field("granted", 32'(want.granted), 32'(got.granted));
                    check_field("grant_slot", 32'(want.grant_slot), 32'(got.grant_slot));
                    check_field("pool_full", 32'(want.pool_full), 32'(got.pool_full));
                    check_field("done_mask", 32'(want.done_mask), 32'(got.done_mask));
                    check_field("busy_mask", 32'(want.busy_mask), 32'(got.busy_mask));
                    check_field("period_flag", 32'(want.period_flag), 32'(got.period_flag));
                end
            end

            if (s_tvalid && s_tready)
            begin
                n_items++;
                apply_pool_item(action_t'(s_tuser), s_tdata[0 +: TICKS_W],
                                s_tdata[TICKS_W +: SLOT_W], s_tdata[TICKS_W + SLOT_W],
                                next_result);
                pool_results_q.push_back(next_result);
            end
        end

        fail_count   <= n_fail;
        pending      <= pool_results_q.size();
        item_count   <= n_items;
        result_count <= n_results;
        grant_count  <= n_grants;
        full_count   <= n_full;
        flag_sets    <= n_flag_sets;
    end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the delay timer pool.
// ----------------------------------------------------------------------------
// A short directed sequence fills the pool, releases some slots and walks the special
// cases, then random phases run under several flag periods, including zero
// and the largest value. Both stream sides idle in random bursts except in
// the last phase. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import dtp_pkg::*;

    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 280;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [PERIOD_W-1:0]   cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // delay_ticks[31:0], slot[35:32], prescale_tick[36]
    logic [ACTION_W-1:0]   s_tuser   = '0;   // action[1:0]
    logic                  m_tready  = 1'b0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [M_TDATA_W-1:0]  m_tdata;          // granted[0], grant_slot[4:1], pool_full[5],
                                             // done_mask[15:6], busy_mask[25:16],
                                             // period_flag[26]

    int fail_count;
    int pending;
    int item_count;
    int result_count;
    int grant_count;
    int full_count;
    int flag_sets;

    bit tx_gaps_on   = 1'b1;
    bit rx_stalls_on = 1'b1;
    int rx_hold      = 0;
    int settings_run = 0;

    logic [PERIOD_W-1:0] period_plan [PHASES] = '{16'd1, 16'd0, 16'd3, 16'd65535,
                                                  16'd500, 16'd17, 16'd2};

    always #1 clk = ~clk;

    delay_timer_pool dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    dtp_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .item_count   (item_count),
        .result_count (result_count),
        .grant_count  (grant_count),
        .full_count   (full_count),
        .flag_sets    (flag_sets)
    );

    // Guard against a hung run.
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // The receiver stalls in bursts of random length while stalls are enabled.
    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end
        else if (rx_stalls_on && $urandom_range(0, 4) == 0)
        begin
            rx_hold  <= $urandom_range(0, 4);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Offers one item, with an optional idle burst first, and waits for its transfer.
    task automatic send_item(input action_t act, input logic [TICKS_W-1:0] dly,
                             input logic [SLOT_W-1:0] sl, input logic ch0);
        if (tx_gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(S_TDATA_W - TICKS_W - SLOT_W - 1){1'b0}}, ch0, sl, dly};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Holds off the sender until every predicted result has arrived.
    task automatic drain_pool();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes the flag period while the block is idle.
    task automatic write_period(input logic [PERIOD_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        settings_run++;
    endtask

    // Random item: ticks most often and mostly short delays so slots expire and get reused.
    task automatic random_item();
        int                  pick;
        action_t             act;
        logic [TICKS_W-1:0]  dly;
        logic [SLOT_W-1:0]   sl;
        pick = $urandom_range(0, 19);
        if (pick < 9)
            act = ACT_TICK;
        else if (pick < 14)
            act = ACT_ALLOC;
        else if (pick < 18)
            act = ACT_RELEASE;
        else
            act = ACT_CLEAR;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            dly = '0;
        else if (pick < 7)
            dly = $urandom_range(1, 12);
        else if (pick == 7)
            dly = $urandom_range(13, 300);
        else if (pick == 8)
            dly = $urandom;
        else
            dly = '1;
        if ($urandom_range(0, 9) == 0)
            sl = SLOT_W'($urandom_range(10, 15));
        else
            sl = SLOT_W'($urandom_range(0, 9));
        send_item(act, dly, sl, 1'($urandom_range(0, 1)));
    endtask

    // Main stimulus sequence.
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: short period so the flag rises early.
        write_period(16'd2);
        send_item(ACT_TICK, 32'd0, 4'd0, 1'b0);
        send_item(ACT_ALLOC, 32'd0, 4'd0, 1'b0);          // zero duration in slot 0
        send_item(ACT_ALLOC, 32'd1, 4'd0, 1'b0);
        send_item(ACT_ALLOC, 32'hFFFF_FFFF, 4'd0, 1'b0);  // longest duration
        send_item(ACT_ALLOC, 32'd2, 4'd0, 1'b0);
        for (int i = 4; i < DTP_NUM_SLOTS; i++)
            send_item(ACT_ALLOC, 32'd5 + i, 4'd0, 1'b0);
        send_item(ACT_ALLOC, 32'd7, 4'd0, 1'b0);          // pool is full here
        send_item(ACT_TICK, 32'd0, 4'd0, 1'b1);
        send_item(ACT_TICK, 32'd0, 4'd0, 1'b1);           // flag rises at period 2
        send_item(ACT_CLEAR, 32'd0, 4'd0, 1'b1);          // expiry bit outside a tick
        send_item(ACT_RELEASE, 32'hFFFF_FFFF, 4'd15, 1'b0);
        send_item(ACT_RELEASE, 32'd0, 4'd10, 1'b0);       // first index past the pool
        send_item(ACT_RELEASE, 32'd0, 4'd0, 1'b0);
        send_item(ACT_RELEASE, 32'd0, 4'd0, 1'b0);        // release of a free slot
        send_item(ACT_ALLOC, 32'd3, 4'd0, 1'b0);          // reuses slot 0, done mark clear
        send_item(ACT_RELEASE, 32'd0, 4'd9, 1'b0);
        send_item(ACT_ALLOC, 32'd1, 4'd15, 1'b1);
        send_item(ACT_TICK, 32'd0, 4'd0, 1'b0);
        send_item(ACT_CLEAR, 32'd0, 4'd0, 1'b0);

        // Random phases, one per flag period setting; the last one runs without idling.
        for (int p = 0; p < PHASES; p++)
        begin
            drain_pool();
            write_period(period_plan[p]);
            if (p == PHASES - 1)
            begin
                tx_gaps_on   = 1'b0;
                rx_stalls_on = 1'b0;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (p == 1 && n == ITEMS_PER_PHASE / 2)
                    drain_pool();
                random_item();
            end
        end

        drain_pool();
        repeat (10) @(posedge clk);

        $display("Covered %0d input transfers and %0d result transfers over %0d flag periods.",
                 item_count, result_count, settings_run);
        $display("Allocations granted %0d, refused on a full pool %0d, period flag raised %0d times.",
                 grant_count, full_count, flag_sets);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
